@@ design/rhrm_pkg.sv @@
package rhrm_pkg;

  // Field widths of the pixel and result beats
  localparam int CH_W    = 8;
  localparam int HUE_W   = 15;
  localparam int SAT_W   = 14;
  localparam int INTEN_W = 14;

  // Register widths
  localparam int HUE_LIM_W = 9;
  localparam int BYTE_LIM_W = 8;

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_HUE_UPPER   = 3'd0,
    REG_HUE_LOWER   = 3'd1,
    REG_SAT_UPPER   = 3'd2,
    REG_SAT_LOWER   = 3'd3,
    REG_INTEN_UPPER = 3'd4,
    REG_INTEN_LOWER = 3'd5
  } reg_idx_t;

endpackage

@@ design/rhrm_if.sv @@
interface rhrm_in_if import rhrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   chan_first;
  logic [CH_W-1:0]   chan_second;
  logic [CH_W-1:0]   chan_third;

  modport source (output valid, chan_first, chan_second, chan_third, input ready);
  modport sink   (input valid, chan_first, chan_second, chan_third, output ready);
endinterface

interface rhrm_out_if import rhrm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HUE_W-1:0]    hue_value;
  logic [SAT_W-1:0]    sat_value;
  logic [INTEN_W-1:0]  inten_value;
  logic                in_range;

  modport source (output valid, hue_value, sat_value, inten_value, in_range, input ready);
  modport sink   (input valid, hue_value, sat_value, inten_value, in_range, output ready);
endinterface

@@ design/rhrm_div.sv @@
module rhrm_div #(
  parameter int XW = 34,
  parameter int DW = 20,
  parameter int QB = 15
) (
  input  logic          clk,
  input  logic [QB-1:0] adv,
  input  logic [XW-1:0] x,
  input  logic [DW-1:0] d,
  output logic [QB-1:0] q
);

  // One quotient bit per stage, restoring; quotient known to be below 2^QB
  logic [DW-1:0] rem_r [QB];
  logic [DW-1:0] d_r   [QB];
  logic [QB-1:0] lo_r  [QB];
  logic [QB-1:0] q_r   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [QB-1:0] lo_in;
    logic [QB-1:0] q_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = DW'(x[XW-1:QB]);
      assign d_in   = d;
      assign lo_in  = x[QB-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign d_in   = d_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign q_in   = q_r[k-1];
    end

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_in, lo_in[QB-1-k]};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem_r[k] <= ge ? DW'(trial - {1'b0, d_in}) : DW'(trial);
        d_r[k]   <= d_in;
        lo_r[k]  <= lo_in;
        q_r[k]   <= q_in | (QB'(ge) << (QB - 1 - k));
      end
    end
  end

  assign q = q_r[QB-1];

endmodule

@@ design/rgb_to_hsi_range_mask_core.sv @@
// Channel   Dir  Handshake         Beat contents
// in_pix    in   valid/ready       chan_first, chan_second, chan_third
// out_res   out  valid/ready       hue_value, sat_value, inten_value, in_range
// cfg (APB) in   psel/penable      six bound registers, byte address 4*index
//
// One pixel enters per clock while out_res does not stall; the pipeline is three arithmetic
// stages, FRAC_BITS+9 one-bit stages of the two quotient pipelines and one output stage.
// The quotient pipelines set the depth: each resolves one quotient bit per stage.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// A stall on out_res holds full stages only; empty stages keep filling.
module rgb_to_hsi_range_mask_core import rhrm_pkg::*; #(
  parameter int FRAC_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rhrm_in_if.sink               in_pix,
  rhrm_out_if.source            out_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int F   = FRAC_BITS;
  localparam int DS  = 9 + F;        // quotient bits and divider stages
  localparam int IW  = 8 + F;        // intensity width
  localparam int NST = DS + 4;       // total pipeline stages
  localparam int HNW = 23;
  localparam int HDW = 17;
  localparam int SNW = 28;
  localparam int SDW = 20;
  localparam logic [IW-1:0] THIRD_1 = IW'((2 ** F) / 3);
  localparam logic [IW-1:0] THIRD_2 = IW'((2 ** (F + 1)) / 3);
  localparam logic [DS-1:0] SAT_MAX = DS'(255) << F;
  localparam logic [DS-1:0] HUE_MAX = DS'(360) << F;

  typedef enum logic [1:0] {SEL_R, SEL_G, SEL_B} hue_sel_t;

  // ---------------- configuration registers ----------------
  logic [HUE_LIM_W-1:0]  hue_upper_r, hue_lower_r;
  logic [BYTE_LIM_W-1:0] sat_upper_r, sat_lower_r, inten_upper_r, inten_lower_r;
  reg_idx_t              reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_upper_r   <= HUE_LIM_W'(360);
      hue_lower_r   <= '0;
      sat_upper_r   <= BYTE_LIM_W'(255);
      sat_lower_r   <= '0;
      inten_upper_r <= BYTE_LIM_W'(255);
      inten_lower_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_HUE_UPPER:   hue_upper_r   <= pwdata[HUE_LIM_W-1:0];
        REG_HUE_LOWER:   hue_lower_r   <= pwdata[HUE_LIM_W-1:0];
        REG_SAT_UPPER:   sat_upper_r   <= pwdata[BYTE_LIM_W-1:0];
        REG_SAT_LOWER:   sat_lower_r   <= pwdata[BYTE_LIM_W-1:0];
        REG_INTEN_UPPER: inten_upper_r <= pwdata[BYTE_LIM_W-1:0];
        REG_INTEN_LOWER: inten_lower_r <= pwdata[BYTE_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_HUE_UPPER:   prdata = APB_DATA_W'(hue_upper_r);
      REG_HUE_LOWER:   prdata = APB_DATA_W'(hue_lower_r);
      REG_SAT_UPPER:   prdata = APB_DATA_W'(sat_upper_r);
      REG_SAT_LOWER:   prdata = APB_DATA_W'(sat_lower_r);
      REG_INTEN_UPPER: prdata = APB_DATA_W'(inten_upper_r);
      REG_INTEN_LOWER: prdata = APB_DATA_W'(inten_lower_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------- stage valids and stall chain ----------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  assign en[NST-1] = !v_r[NST-1] || out_res.ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  assign in_pix.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_pix.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // ---------------- stage A: sum, minimum, hue operands ----------------
  logic [9:0]      sum_a;
  hue_sel_t        sel_a;
  logic [7:0]      min_a, num_a;
  logic [8:0]      den_a;
  logic [7:0]      r_in, g_in, b_in;

  logic [9:0]      sum_a_r;
  logic [7:0]      min_a_r, num_a_r;
  logic [8:0]      den_a_r;
  hue_sel_t        sel_a_r;
  logic            eq_a_r;

  assign r_in  = in_pix.chan_first;
  assign g_in  = in_pix.chan_second;
  assign b_in  = in_pix.chan_third;
  assign sum_a = 10'(r_in) + 10'(g_in) + 10'(b_in);

  // Pick the smallest channel, red first, then green
  always_comb begin
    if (r_in <= g_in && r_in <= b_in) begin
      sel_a = SEL_R;
      min_a = r_in;
      num_a = b_in - r_in;
      den_a = 9'(g_in) + 9'(b_in) - {r_in, 1'b0};
    end else if (g_in <= b_in) begin
      sel_a = SEL_G;
      min_a = g_in;
      num_a = r_in - g_in;
      den_a = 9'(r_in) + 9'(b_in) - {g_in, 1'b0};
    end else begin
      sel_a = SEL_B;
      min_a = b_in;
      num_a = g_in - b_in;
      den_a = 9'(r_in) + 9'(g_in) - {b_in, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sum_a_r <= sum_a;
      min_a_r <= min_a;
      num_a_r <= num_a;
      den_a_r <= den_a;
      sel_a_r <= sel_a;
      eq_a_r  <= (r_in == g_in) || (g_in == b_in);
    end
  end

  // ---------------- stage B: intensity, saturation and hue fractions ----------------
  logic [18:0]     q3_prod;
  logic [7:0]      q3;
  logic [1:0]      rem3;
  logic [IW-1:0]   inten_b;
  logic [SDW-1:0]  dd_b, sn_b;
  logic [HNW-1:0]  hn_b;
  logic [HDW-1:0]  hd_b;

  logic [IW-1:0]   inten_b_r;
  logic [SDW-1:0]  dd_b_r, sn_b_r;
  logic [HNW-1:0]  hn_b_r;
  logic [HDW-1:0]  hd_b_r;
  logic            eq_b_r;

  // Divide the sum by three through a reciprocal, then add the remainder's fraction
  assign q3_prod = 19'(sum_a_r) * 19'd683;
  assign q3      = q3_prod[18:11];
  assign rem3    = 2'(sum_a_r - ((10'(q3) << 1) + 10'(q3)));

  always_comb begin
    inten_b = IW'(q3) << F;
    if (rem3 == 2'd1) inten_b = inten_b + THIRD_1;
    else if (rem3 == 2'd2) inten_b = inten_b + THIRD_2;
  end

  assign dd_b = SDW'(sum_a_r) * SDW'(1000) + SDW'(765);
  assign sn_b = dd_b - SDW'(min_a_r) * SDW'(3000);

  // Hue as 2^F * N / D with the offset folded into N
  always_comb begin
    unique case (sel_a_r)
      SEL_R: begin
        hn_b = HNW'(10'(num_a_r) + 10'(den_a_r)) * HNW'(120);
        hd_b = HDW'(den_a_r);
      end
      SEL_G: begin
        hn_b = HNW'(11'(num_a_r) + (11'(den_a_r) << 1)) * HNW'(120);
        hd_b = HDW'(den_a_r);
      end
      default: begin
        hn_b = HNW'(num_a_r) * HNW'(30000) + HNW'(den_a_r) * HNW'(9);
        hd_b = HDW'(den_a_r) * HDW'(250);
      end
    endcase
    // Flat pixel: hue is zero
    if (den_a_r == '0) begin
      hn_b = '0;
      hd_b = HDW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      inten_b_r <= inten_b;
      dd_b_r    <= dd_b;
      sn_b_r    <= sn_b;
      hn_b_r    <= hn_b;
      hd_b_r    <= hd_b;
      eq_b_r    <= eq_a_r;
    end
  end

  // ---------------- stage C: scale the saturation numerator ----------------
  logic [SNW-1:0]  sn_c_r;
  logic [SDW-1:0]  dd_c_r;
  logic [HNW-1:0]  hn_c_r;
  logic [HDW-1:0]  hd_c_r;
  logic [IW-1:0]   inten_c_r;
  logic            eq_c_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sn_c_r    <= SNW'(sn_b_r) * SNW'(255);
      dd_c_r    <= dd_b_r;
      hn_c_r    <= hn_b_r;
      hd_c_r    <= hd_b_r;
      inten_c_r <= inten_b_r;
      eq_c_r    <= eq_b_r;
    end
  end

  // ---------------- quotient pipelines ----------------
  logic [DS-1:0] sat_q, hue_q;

  rhrm_div #(.XW(SNW + F), .DW(SDW), .QB(DS)) u_sat_div (
    .clk (clk),
    .adv (en[3 +: DS]),
    .x   ({sn_c_r, F'(0)}),
    .d   (dd_c_r),
    .q   (sat_q)
  );

  rhrm_div #(.XW(HNW + F), .DW(HDW), .QB(DS)) u_hue_div (
    .clk (clk),
    .adv (en[3 +: DS]),
    .x   ({hn_c_r, F'(0)}),
    .d   (hd_c_r),
    .q   (hue_q)
  );

  // Carry intensity and the equal-channel flag alongside the quotients
  logic [IW-1:0] sb_inten_r [DS];
  logic          sb_eq_r    [DS];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sb_inten_r[0] <= inten_c_r;
      sb_eq_r[0]    <= eq_c_r;
    end
    for (int k = 1; k < DS; k++) begin
      if (en[3+k]) begin
        sb_inten_r[k] <= sb_inten_r[k-1];
        sb_eq_r[k]    <= sb_eq_r[k-1];
      end
    end
  end

  // ---------------- output stage: bound test ----------------
  logic [DS-1:0]      test_hue, hue_lo, hue_hi, sat_lo, sat_hi;
  logic [IW-1:0]      int_lo, int_hi, inten_o;
  logic               hue_ok, sat_ok, int_ok;
  logic [DS+14:0]     hue_ext;
  logic [DS+13:0]     sat_ext;
  logic [IW+13:0]     int_ext;

  logic [HUE_W-1:0]   hue_o_r;
  logic [SAT_W-1:0]   sat_o_r;
  logic [INTEN_W-1:0] inten_o_r;
  logic               pass_o_r;

  assign inten_o  = sb_inten_r[DS-1];
  assign test_hue = sb_eq_r[DS-1] ? '0 : hue_q;
  assign hue_lo   = DS'(hue_lower_r) << F;
  assign hue_hi   = DS'(hue_upper_r) << F;
  assign sat_lo   = DS'(sat_lower_r) << F;
  assign sat_hi   = DS'(sat_upper_r) << F;
  assign int_lo   = IW'(inten_lower_r) << F;
  assign int_hi   = IW'(inten_upper_r) << F;

  // Wrapped hue window when lower exceeds upper
  assign hue_ok = (hue_lower_r > hue_upper_r) ?
                  (test_hue >= hue_lo || test_hue <= hue_hi) :
                  (test_hue >= hue_lo && test_hue <= hue_hi);
  assign sat_ok = (sat_q >= sat_lo) && (sat_q <= sat_hi);
  assign int_ok = (inten_o >= int_lo) && (inten_o <= int_hi);

  assign hue_ext = (DS + 15)'(hue_q);
  assign sat_ext = (DS + 14)'(sat_q);
  assign int_ext = (IW + 14)'(inten_o);

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      hue_o_r   <= hue_ext[HUE_W-1:0];
      sat_o_r   <= sat_ext[SAT_W-1:0];
      inten_o_r <= int_ext[INTEN_W-1:0];
      pass_o_r  <= hue_ok && sat_ok && int_ok;
    end
  end

  assign out_res.valid       = v_r[NST-1];
  assign out_res.hue_value   = hue_o_r;
  assign out_res.sat_value   = sat_o_r;
  assign out_res.inten_value = inten_o_r;
  assign out_res.in_range    = pass_o_r;

`ifndef SYNTHESIS
  // An accepted pixel occupies the first stage on the next cycle
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> v_r[0])
    else $error("accepted pixel missing from first stage");

  // A blocked last quotient stage keeps its beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NST-2] && !en[NST-2]) |=> v_r[NST-2])
    else $error("stalled quotient stage lost its beat");

  // Quotients stay inside their ranges
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-2] |-> (sat_q <= SAT_MAX))
    else $error("saturation quotient out of range");

  a_hue_max: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-2] |-> (hue_q <= HUE_MAX))
    else $error("hue quotient out of range");
`endif

endmodule

@@ tb/sv/tb_rgb_to_hsi_range_mask_core.sv @@
module tb_rgb_to_hsi_range_mask_core;
  import rhrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 6;
  localparam int LATENCY = FRAC + 13;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [SAT_W-1:0]   sat;
    logic [INTEN_W-1:0] inten;
    logic               pass;
  } hsi_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  rhrm_in_if  in_pix ();
  rhrm_out_if out_res ();

  rgb_to_hsi_range_mask_core #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n), .in_pix(in_pix.sink), .out_res(out_res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the bound registers
  logic [HUE_LIM_W-1:0]  hue_hi, hue_lo;
  logic [BYTE_LIM_W-1:0] sat_hi, sat_lo, inten_hi, inten_lo;

  pixel_t pixel_q[$];
  hsi_t   hsi_expected_q[$];
  int     mismatches;
  int     idle_cycles;
  bit     timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hue in degrees * 2^F for num/(3*den) + on/od
  function automatic longint unsigned hue_frac(longint unsigned num, longint unsigned den,
                                               longint unsigned on, longint unsigned od);
    longint unsigned top, bot;
    top = num * od + 3 * den * on;
    bot = 3 * den * od;
    return ((64'd360 << FRAC) * top) / bot;
  endfunction

  function automatic bit in_bounds(longint unsigned v, longint unsigned lo,
                                   longint unsigned hi);
    return v >= (lo << FRAC) && v <= (hi << FRAC);
  endfunction

  function automatic hsi_t convert_pixel(pixel_t p);
    longint unsigned r, g, b, total, mn, dd, den, hue, sat, inten, thue;
    bit hue_ok;
    hsi_t res;
    r = p.r; g = p.g; b = p.b;
    total = r + g + b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    inten = (total << FRAC) / 3;
    dd = 1000 * total + 765;
    sat = ((64'd255 << FRAC) * (dd - 3000 * mn)) / dd;
    if (mn == r) begin
      den = g + b - 2 * r;
      hue = (den == 0) ? 0 : hue_frac(b - r, den, 1, 3);
    end else if (mn == g) begin
      den = r + b - 2 * g;
      hue = (den == 0) ? 0 : hue_frac(r - g, den, 2, 3);
    end else begin
      den = r + g - 2 * b;
      hue = (den == 0) ? 0 : hue_frac(g - b, den, 1, 10000);
    end
    if (total == 0) hue = 0;
    thue = (r == g || g == b) ? 0 : hue;
    if (hue_lo > hue_hi)
      hue_ok = thue >= (longint'(hue_lo) << FRAC) || thue <= (longint'(hue_hi) << FRAC);
    else
      hue_ok = in_bounds(thue, hue_lo, hue_hi);
    res.hue = hue[HUE_W-1:0];
    res.sat = sat[SAT_W-1:0];
    res.inten = inten[INTEN_W-1:0];
    res.pass = hue_ok && in_bounds(sat, sat_lo, sat_hi) && in_bounds(inten, inten_lo, inten_hi);
    return res;
  endfunction

  // Driver: bursts of beats with random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_pix.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_pix.valid && in_pix.ready) begin
        hsi_expected_q.push_back(convert_pixel(pixel_q.pop_front()));
      end
      if (in_pix.valid && !in_pix.ready) begin
        // hold the beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_pix.valid <= 1'b0;
      end else if (pixel_q.size() > 0 && !(in_pix.valid && pixel_q.size() == 0)) begin
        in_pix.valid <= 1'b1;
        in_pix.chan_first  <= pixel_q[0].r;
        in_pix.chan_second <= pixel_q[0].g;
        in_pix.chan_third  <= pixel_q[0].b;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_pix.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  int stall_mode;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        if (hsi_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
        end else begin
          hsi_t exp_res;
          exp_res = hsi_expected_q.pop_front();
          if (exp_res.hue !== out_res.hue_value || exp_res.sat !== out_res.sat_value ||
              exp_res.inten !== out_res.inten_value || exp_res.pass !== out_res.in_range) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: exp hue %0d sat %0d inten %0d pass %0d, got %0d %0d %0d %0d",
                       exp_res.hue, exp_res.sat, exp_res.inten, exp_res.pass,
                       out_res.hue_value, out_res.sat_value, out_res.inten_value,
                       out_res.in_range);
          end
        end
      end
      // Switch stall pattern now and then
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_res.ready <= 1'b1;
        1: out_res.ready <= ($urandom_range(0, 3) != 0);
        2: out_res.ready <= ($urandom_range(0, 1) != 0);
        default: out_res.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_pix.valid && in_pix.ready) || (out_res.valid && out_res.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic reg_write(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * int'(idx)); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_HUE_UPPER:   hue_hi = val[HUE_LIM_W-1:0];
      REG_HUE_LOWER:   hue_lo = val[HUE_LIM_W-1:0];
      REG_SAT_UPPER:   sat_hi = val[BYTE_LIM_W-1:0];
      REG_SAT_LOWER:   sat_lo = val[BYTE_LIM_W-1:0];
      REG_INTEN_UPPER: inten_hi = val[BYTE_LIM_W-1:0];
      REG_INTEN_LOWER: inten_lo = val[BYTE_LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_bounds(int hh, int hl, int sh, int sl, int ih, int il);
    reg_write(REG_HUE_UPPER, hh);
    reg_write(REG_HUE_LOWER, hl);
    reg_write(REG_SAT_UPPER, sh);
    reg_write(REG_SAT_LOWER, sl);
    reg_write(REG_INTEN_UPPER, ih);
    reg_write(REG_INTEN_LOWER, il);
  endtask

  task automatic push_pixel(int r, int g, int b);
    pixel_t p;
    p.r = r; p.g = g; p.b = b;
    pixel_q.push_back(p);
  endtask

  // Wait until every beat is sent and checked, then let the pipeline drain
  task automatic drain();
    while ((pixel_q.size() > 0 || in_pix.valid || hsi_expected_q.size() > 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      repeat (LATENCY + 5) @(posedge clk);
    end
  endtask

  task automatic push_random(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        int v;
        v = $urandom_range(0, 255);
        push_pixel(v, v, $urandom_range(0, 255));
      end else if (kind == 1) begin
        int v;
        v = $urandom_range(0, 255);
        push_pixel($urandom_range(0, 255), v, v);
      end else if (kind == 2) begin
        push_pixel($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
      end else begin
        push_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_pix.valid = 1'b0;
    in_pix.chan_first = '0; in_pix.chan_second = '0; in_pix.chan_third = '0;
    out_res.ready = 1'b0;
    mismatches = 0;
    hue_hi = 360; hue_lo = 0; sat_hi = 255; sat_lo = 0; inten_hi = 255; inten_lo = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, each smallest-channel branch, equal channels
    push_pixel(0, 0, 0);
    push_pixel(255, 255, 255);
    push_pixel(255, 0, 0);
    push_pixel(0, 255, 0);
    push_pixel(0, 0, 255);
    push_pixel(10, 200, 100);
    push_pixel(200, 10, 100);
    push_pixel(200, 100, 10);
    push_pixel(50, 50, 200);
    push_pixel(200, 50, 50);
    push_pixel(50, 200, 50);
    push_pixel(1, 0, 0);
    push_pixel(0, 0, 1);
    push_pixel(170, 85, 0);
    push_pixel(128, 127, 126);
    drain();

    // Narrow bounds, then wrapped hue range, then extremes, then random bounds
    write_bounds(120, 60, 200, 50, 180, 20);
    push_random(250);
    drain();
    write_bounds(40, 300, 255, 0, 255, 0);
    push_random(250);
    drain();
    write_bounds(0, 511, 0, 255, 0, 255);
    push_random(100);
    drain();
    write_bounds(511, 0, 255, 0, 255, 0);
    push_random(150);
    drain();
    write_bounds($urandom_range(0, 360), $urandom_range(0, 360), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    push_random(250);
    drain();

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
